// File: rtl/fire_effect_stencil_filter_defines.svh
// Assertion macros shared by the checker of the fire effect stencil filter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIRE_EFFECT_STENCIL_FILTER_DEFINES_SVH
`define FIRE_EFFECT_STENCIL_FILTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FES_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fire effect filter check failed");

// Consequent checked in the cycle after the antecedent.
`define FES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fire effect filter check failed");

`endif

// File: rtl/fes_pkg.sv
// Types and constants of the fire effect stencil filter.
// Used by all RTL modules of the block but the line store; depends on nothing.
package fes_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KERNEL_SELECT = 2'd0;
  localparam logic [1:0] CFG_LINE_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd2;

  localparam logic       KERNEL_AVG8   = 1'b0;

  localparam logic [9:0] RST_LINE_WIDTH   = 10'd320;
  localparam logic [8:0] RST_FRAME_HEIGHT = 9'd240;

  // floor(32*s/129) == (s * 32514) >> 17 exactly for every s below 2^16.
  localparam logic [14:0] RECIP_129   = 15'd32514;
  localparam int          RECIP_SHIFT = 17;

  // Result queue between the kernel and the output port.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic       produce;
    logic       done;
    logic [8:0] col;
    logic [7:0] row;
  } meta_t;

  typedef struct packed {
    logic [10:0] sum8;
    logic [9:0]  sum4;
    meta_t       meta;
  } sums_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [8:0] col;
    logic [7:0] row;
    logic       done;
  } res_t;

endpackage

// File: rtl/fire_effect_stencil_filter.sv
// Fire effect stencil filter: line stores, 3x3 window and kernel over a pixel stream.
// A result goes through the input register, the window sum register and the output queue.
// One pixel per cycle unless in_stall is high, set by the line store read and write ports.
// in_stall rises only when eight results are in flight or queued, all waiting on out_stall.
// Synchronous active-low reset clears position, window, queue and the configuration to
// its defaults; the line stores are not cleared and hold stale data until rewritten.
module fire_effect_stencil_filter import fes_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixel_in,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pixel_out,
  output logic [8:0] out_column,
  output logic [7:0] out_row,
  output logic       out_frame_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = (CW + 1 > 10) ? CW + 1 : 10;
  localparam int YW = (RW + 1 > 9) ? RW + 1 : 9;

  logic          kernel_r;
  logic [9:0]    width_r;
  logic [8:0]    height_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [XW-1:0] w_eff, cs, nc, cm1;
  logic [YW-1:0] h_eff, rs, nr, rm2;
  logic          in_xfer;
  meta_t         meta0;

  logic          s1_valid_r;
  logic [7:0]    s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  meta_t         s1_meta_r;
  logic [15:0]   store_rd;

  logic          sum_valid;
  sums_t         sums;
  logic          push;
  res_t          res;
  res_t          head;
  logic          out_xfer;

  logic [OQ_CW-1:0] cred_r, cred_nxt;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= 1'b1;
      width_r  <= RST_LINE_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KERNEL_SELECT: kernel_r <= cfg_data[0];
        CFG_LINE_WIDTH:    width_r  <= cfg_data;
        CFG_FRAME_HEIGHT:  height_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Position of the arriving pixel
  always_comb begin
    w_eff = XW'(width_r);
    if (w_eff < XW'(3)) w_eff = XW'(3);
    if (w_eff > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    h_eff = YW'(height_r);
    if (h_eff < YW'(3)) h_eff = YW'(3);
    if (h_eff > YW'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);

    cs = in_frame_start ? '0 : XW'(col_r);
    rs = in_frame_start ? '0 : YW'(row_r);
    // A geometry change may leave the stored position outside the frame.
    if (cs >= w_eff) begin
      cs = '0;
      rs = rs + YW'(1);
    end
    if (rs >= h_eff) rs = '0;

    nc = cs + XW'(1);
    nr = rs;
    if (nc >= w_eff) begin
      nc = '0;
      nr = rs + YW'(1);
      if (nr >= h_eff) nr = '0;
    end
    col_nxt = nc[CW-1:0];
    row_nxt = nr[RW-1:0];

    cm1 = cs - XW'(1);
    rm2 = rs - YW'(2);
    meta0.produce = (rs >= YW'(2)) && (cs >= XW'(2));
    meta0.done    = (rs == h_eff - YW'(1)) && (cs == w_eff - XW'(1));
    meta0.col     = cm1[8:0];
    meta0.row     = rm2[7:0];
  end

  assign in_stall = (cred_r >= OQ_CW'(OQ_DEPTH));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r  <= in_pixel_in;
      s1_addr_r <= cs[CW-1:0];
      s1_meta_r <= meta0;
    end
  end

  // Each column entry moves newer to older and takes the new pixel as newer.
  fes_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (cs[CW-1:0]),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data ({store_rd[7:0], s1_pix_r}),
    .rd_data (store_rd)
  );

  fes_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .store_rd  (store_rd),
    .pix       (s1_pix_r),
    .meta      (s1_meta_r),
    .sum_valid (sum_valid),
    .sums      (sums)
  );

  fes_kernel u_kernel (
    .sum_valid     (sum_valid),
    .sums          (sums),
    .kernel_select (kernel_r),
    .push          (push),
    .res           (res)
  );

  fes_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .pop        (out_xfer),
    .head_valid (out_valid),
    .head       (head)
  );

  // Credits count results in the pipeline plus those in the queue, so the
  // queue always has a slot for anything already accepted.
  always_comb begin
    cred_nxt = cred_r;
    if (in_xfer && meta0.produce) cred_nxt = cred_nxt + OQ_CW'(1);
    if (out_xfer) cred_nxt = cred_nxt - OQ_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
    end
  end

  assign out_pixel_out  = head.pixel;
  assign out_column     = head.col;
  assign out_row        = head.row;
  assign out_frame_done = head.done;

endmodule

// File: rtl/fes_line_store.sv
// Dual line store: one entry per column holding the two previous rows.
// Synchronous read with a bypass for a write to the same entry in the read cycle.
module fes_line_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q_r;
  logic [15:0] byp_data_r;
  logic        byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // The array returns the old entry when read and write collide, so the
  // new value is taken from the write port instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

// File: rtl/fes_window.sv
// 3x3 window of the filter and the two kernel sums over it.
// Depends on fes_pkg; fed by the line store read data and the arriving pixel.
module fes_window import fes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] store_rd,
  input  logic [7:0]  pix,
  input  meta_t       meta,
  output logic        sum_valid,
  output sums_t       sums
);

  logic [7:0]  win_r   [3][3];
  logic [7:0]  win_nxt [3][3];
  logic [7:0]  new_col [3];
  logic [10:0] sum8;
  logic [9:0]  sum4;
  logic        sum_valid_r;
  sums_t       sums_r;

  always_comb begin
    new_col[0] = store_rd[15:8];
    new_col[1] = store_rd[7:0];
    new_col[2] = pix;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
      win_nxt[k][2] = new_col[k];
    end
  end

  assign sum8 = 11'(win_nxt[0][0]) + 11'(win_nxt[0][2])
              + 11'(win_nxt[1][0]) + 11'(win_nxt[1][1]) + 11'(win_nxt[1][2])
              + 11'(win_nxt[2][0]) + 11'(win_nxt[2][1]) + 11'(win_nxt[2][2]);
  assign sum4 = 10'(win_nxt[1][0]) + 10'(win_nxt[1][1]) + 10'(win_nxt[1][2])
              + 10'(win_nxt[2][1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
      sum_valid_r <= 1'b0;
    end else begin
      if (in_valid) begin
        win_r <= win_nxt;
      end
      sum_valid_r <= in_valid && meta.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      sums_r.sum8 <= sum8;
      sums_r.sum4 <= sum4;
      sums_r.meta <= meta;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sums      = sums_r;

endmodule

// File: rtl/fes_kernel.sv
// Final kernel step: eight-tap average or weighted four-tap scaling by 32/129.
// Depends on fes_pkg; the result goes straight into the output queue.
module fes_kernel import fes_pkg::*; (
  input  logic  sum_valid,
  input  sums_t sums,
  input  logic  kernel_select,
  output logic  push,
  output res_t  res
);

  logic [24:0] prod;
  logic [24:0] quot;

  assign prod = 25'(sums.sum4) * 25'(RECIP_129);
  assign quot = prod >> RECIP_SHIFT;

  always_comb begin
    res.pixel = (kernel_select == KERNEL_AVG8) ? sums.sum8[10:3] : quot[7:0];
    res.col   = sums.meta.col;
    res.row   = sums.meta.row;
    res.done  = sums.meta.done;
  end

  assign push = sum_valid;

endmodule

// File: rtl/fes_out_fifo.sv
// Result queue in front of the output port.
// Depends on fes_pkg; room is reserved upstream, so a push never finds it full.
module fes_out_fifo import fes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic head_valid,
  output res_t head
);

  res_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r;
  logic [OQ_AW-1:0] rp_r;
  logic [OQ_CW-1:0] cnt_r;
  logic [OQ_CW-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wp_r + OQ_AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rp_r + OQ_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];

endmodule

// File: rtl/fes_checker.sv
// Port-level checks of the fire effect stencil filter, bound to its top level.
// Depends on fire_effect_stencil_filter_defines.svh for the assertion macros.
`include "fire_effect_stencil_filter_defines.svh"

module fes_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_out,
  input logic [8:0] out_column,
  input logic [7:0] out_row,
  input logic       out_frame_done
);

  logic        in_xfer;
  logic [25:0] out_payload;

  assign in_xfer     = in_valid && !in_stall;
  assign out_payload = {out_pixel_out, out_column, out_row, out_frame_done};

  // No input transfer in any cycle of the sequence, and an empty output in its last cycle.
  sequence s_drained;
    !in_xfer ##1 !in_xfer ##1 !in_xfer ##1 (!in_xfer && !out_valid);
  endsequence

  `FES_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid)
  `FES_ASSERT_NEXT(a_out_payload_holds, out_valid && out_stall, $stable(out_payload))
  // The input only backs up once the output queue itself is holding results.
  `FES_ASSERT_SAME(a_stall_needs_backlog, in_stall, out_valid)
  // With no transfer throughout s_drained the pipeline is empty, so an empty
  // output cannot fill up again.
  `FES_ASSERT_NEXT(a_drained_stays_empty, s_drained, !out_valid)

endmodule

bind fire_effect_stencil_filter fes_checker u_fes_checker (.*);
